@@ src/glyph_range_lookup_width_sum_unit_defines.svh @@
// assertion macros for the glyph range lookup width sum unit
`ifndef GLYPH_RANGE_LOOKUP_WIDTH_SUM_UNIT_DEFINES_SVH
`define GLYPH_RANGE_LOOKUP_WIDTH_SUM_UNIT_DEFINES_SVH

// same cycle implication, checked out of reset
`define GLRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication, checked out of reset
`define GLRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/glru_pkg.sv @@
// shared types and constants of the glyph range lookup width sum unit
`default_nettype none

package glru_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned GLYPH_W  = 10;
  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned TOTAL_W  = 24;
  localparam int unsigned SUM_W    = TOTAL_W + 1;
  localparam int unsigned GSUM_W   = CP_W + 1;
  localparam int unsigned RIU_W    = 9;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [OPCODE_W-1:0] OP_LOAD_RANGE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_WIDTH = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MEASURE    = 2'd2;

  localparam logic REG_RANGES_IN_USE = 1'b0;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [CP_W-1:0]    upper;
    logic [CP_W-1:0]    lower;
    logic [GLYPH_W-1:0] base;
  } range_entry_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   slot;
    logic [CP_W-1:0]     code_point;
    logic [CP_W-1:0]     range_low;
    logic [CP_W-1:0]     range_high;
    logic [GLYPH_W-1:0]  first_glyph;
    logic [PIXEL_W-1:0]  pixel_width;
    logic                last_char;
  } item_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_number;
    logic               found;
    logic [TOTAL_W-1:0] total_width;
    logic               string_done;
  } result_t;

endpackage

`default_nettype wire

@@ src/glyph_range_lookup_width_sum_unit.sv @@
// measure item: k search steps over the range table, then a width read, an accumulate and the output register
// k is at most floor(log2(n)) + 1 for n ranges in use (0 when n is 0), at most 9 for 256
// one item in flight: input is not ready again until the measure result is taken, so output stalls hold it
// load items are written when accepted, unused opcodes are dropped
// reset clears control state, running total and ranges_in_use, tables undefined until loaded
// top level of the glyph range lookup width sum unit
`default_nettype none

module glyph_range_lookup_width_sum_unit #(
  parameter int unsigned RANGE_ENTRIES = 256,
  parameter int unsigned GLYPH_ENTRIES = 1024
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [glru_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire [glru_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [glru_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // slot, code_point, range_low, range_high, first_glyph, pixel_width, zero fill
  input  wire [95:0]                         s_axis_tdata,
  // opcode
  input  wire [1:0]                          s_axis_tuser,
  input  wire                                s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // glyph_number, total_width, zero fill
  output logic [39:0]                        m_axis_tdata,
  // found
  output logic [0:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned RANGE_AW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
  localparam int unsigned GLYPH_AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;

  logic [glru_pkg::RIU_W-1:0]     riu_q;
  logic                           cfg_wr;

  glru_pkg::item_t                item;
  glru_pkg::result_t              res;
  logic                           res_valid;
  logic                           res_ready;
  glru_pkg::result_t              out_q;
  logic                           out_valid_q;

  logic                           range_we;
  logic [RANGE_AW-1:0]            range_waddr;
  glru_pkg::range_entry_t         range_wdata;
  logic                           range_re;
  logic [RANGE_AW-1:0]            range_raddr;
  glru_pkg::range_entry_t         range_rdata;
  logic                           width_we;
  logic [GLYPH_AW-1:0]            width_waddr;
  logic [glru_pkg::PIXEL_W-1:0]   width_wdata;
  logic                           width_re;
  logic [GLYPH_AW-1:0]            width_raddr;
  logic [glru_pkg::PIXEL_W-1:0]   width_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == glru_pkg::REG_RANGES_IN_USE);
  assign prdata = (psel && (paddr[2] == glru_pkg::REG_RANGES_IN_USE)) ?
                  glru_pkg::APB_DATA_W'(riu_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      riu_q <= '0;
    end else if (cfg_wr) begin
      riu_q <= pwdata[glru_pkg::RIU_W-1:0];
    end
  end

  assign item.opcode      = s_axis_tuser;
  assign item.slot        = s_axis_tdata[9:0];
  assign item.code_point  = s_axis_tdata[30:10];
  assign item.range_low   = s_axis_tdata[51:31];
  assign item.range_high  = s_axis_tdata[72:52];
  assign item.first_glyph = s_axis_tdata[82:73];
  assign item.pixel_width = s_axis_tdata[90:83];
  assign item.last_char   = s_axis_tlast;

  glru_ctrl #(
    .RANGE_ENTRIES (RANGE_ENTRIES),
    .GLYPH_ENTRIES (GLYPH_ENTRIES),
    .RANGE_AW      (RANGE_AW),
    .GLYPH_AW      (GLYPH_AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ranges_in_use_i (riu_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .item_i          (item),
    .range_we_o      (range_we),
    .range_waddr_o   (range_waddr),
    .range_wdata_o   (range_wdata),
    .range_re_o      (range_re),
    .range_raddr_o   (range_raddr),
    .range_rdata_i   (range_rdata),
    .width_we_o      (width_we),
    .width_waddr_o   (width_waddr),
    .width_wdata_o   (width_wdata),
    .width_re_o      (width_re),
    .width_raddr_o   (width_raddr),
    .width_rdata_i   (width_rdata),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  glru_range_store #(
    .DEPTH (RANGE_ENTRIES),
    .AW    (RANGE_AW)
  ) u_range_store (
    .clk_i   (clk_i),
    .we_i    (range_we),
    .waddr_i (range_waddr),
    .wdata_i (range_wdata),
    .re_i    (range_re),
    .raddr_i (range_raddr),
    .rdata_o (range_rdata)
  );

  glru_width_store #(
    .DEPTH (GLYPH_ENTRIES),
    .AW    (GLYPH_AW)
  ) u_width_store (
    .clk_i   (clk_i),
    .we_i    (width_we),
    .waddr_i (width_waddr),
    .wdata_i (width_wdata),
    .re_i    (width_re),
    .raddr_i (width_raddr),
    .rdata_o (width_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.total_width, out_q.glyph_number};
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tlast  = out_q.string_done;

endmodule

`default_nettype wire

@@ src/glru_range_store.sv @@
// range table memory, one write and one registered read port
`default_nettype none

module glru_range_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire                        clk_i,
  input  wire                        we_i,
  input  wire [AW-1:0]               waddr_i,
  input  glru_pkg::range_entry_t     wdata_i,
  input  wire                        re_i,
  input  wire [AW-1:0]               raddr_i,
  output glru_pkg::range_entry_t     rdata_o
);

  glru_pkg::range_entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/glru_width_store.sv @@
// glyph width memory, one write and one registered read port
`default_nettype none

module glru_width_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire                            clk_i,
  input  wire                            we_i,
  input  wire [AW-1:0]                   waddr_i,
  input  wire [glru_pkg::PIXEL_W-1:0]    wdata_i,
  input  wire                            re_i,
  input  wire [AW-1:0]                   raddr_i,
  output logic [glru_pkg::PIXEL_W-1:0]   rdata_o
);

  logic [glru_pkg::PIXEL_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/glru_ctrl.sv @@
// table load, binary search and width accumulate sequencer
`default_nettype none
`include "glyph_range_lookup_width_sum_unit_defines.svh"

module glru_ctrl #(
  parameter int unsigned RANGE_ENTRIES = 256,
  parameter int unsigned GLYPH_ENTRIES = 1024,
  parameter int unsigned RANGE_AW      = 8,
  parameter int unsigned GLYPH_AW      = 10
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire [glru_pkg::RIU_W-1:0]        ranges_in_use_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  glru_pkg::item_t                  item_i,
  output logic                             range_we_o,
  output logic [RANGE_AW-1:0]              range_waddr_o,
  output glru_pkg::range_entry_t           range_wdata_o,
  output logic                             range_re_o,
  output logic [RANGE_AW-1:0]              range_raddr_o,
  input  glru_pkg::range_entry_t           range_rdata_i,
  output logic                             width_we_o,
  output logic [GLYPH_AW-1:0]              width_waddr_o,
  output logic [glru_pkg::PIXEL_W-1:0]     width_wdata_o,
  output logic                             width_re_o,
  output logic [GLYPH_AW-1:0]              width_raddr_o,
  input  wire [glru_pkg::PIXEL_W-1:0]      width_rdata_i,
  output logic                             res_valid_o,
  input  wire                              res_ready_i,
  output glru_pkg::result_t                res_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_ACCUM  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [glru_pkg::RIU_W-1:0]      n_q, n_d;
  logic [glru_pkg::RIU_W-1:0]      first_q, first_d;
  logic [glru_pkg::RIU_W-1:0]      count_q, count_d;
  logic [glru_pkg::CP_W-1:0]       cp_q, cp_d;
  logic                            last_q, last_d;
  logic                            hit_q, hit_d;
  logic [glru_pkg::GLYPH_W-1:0]    glyph_q, glyph_d;
  logic [glru_pkg::TOTAL_W-1:0]    total_q, total_d;

  logic [glru_pkg::RIU_W-1:0]      n_lim;
  logic [glru_pkg::RIU_W-1:0]      step;
  logic [glru_pkg::RIU_W-1:0]      probe;
  logic                            probe_below;
  logic [glru_pkg::RIU_W-1:0]      first_nx;
  logic [glru_pkg::RIU_W-1:0]      count_nx;
  logic [glru_pkg::GSUM_W-1:0]     glyph_full;
  logic                            hit_now;
  logic [glru_pkg::SUM_W-1:0]      sum_w;
  logic [glru_pkg::TOTAL_W-1:0]    sum_sat;

  assign n_lim = (32'(ranges_in_use_i) > RANGE_ENTRIES) ?
                 glru_pkg::RIU_W'(RANGE_ENTRIES) : ranges_in_use_i;

  assign step        = count_q >> 1;
  assign probe       = first_q + step;
  assign probe_below = range_rdata_i.upper < cp_q;
  assign first_nx    = probe_below ? probe + glru_pkg::RIU_W'(1) : first_q;
  assign count_nx    = probe_below ? count_q - step - glru_pkg::RIU_W'(1) : step;

  assign glyph_full = glru_pkg::GSUM_W'(range_rdata_i.base) +
                      glru_pkg::GSUM_W'(cp_q - range_rdata_i.lower);
  assign hit_now    = (first_q < n_q) && (cp_q >= range_rdata_i.lower) &&
                      (cp_q <= range_rdata_i.upper) &&
                      (32'(glyph_full) < GLYPH_ENTRIES);

  assign sum_w   = glru_pkg::SUM_W'(total_q) +
                   glru_pkg::SUM_W'(hit_q ? width_rdata_i : '0);
  assign sum_sat = sum_w[glru_pkg::TOTAL_W] ? glru_pkg::TOTAL_MAX :
                   sum_w[glru_pkg::TOTAL_W-1:0];

  assign in_ready_o          = (state_q == ST_IDLE);
  assign range_waddr_o       = RANGE_AW'(item_i.slot);
  assign range_wdata_o.upper = item_i.range_high;
  assign range_wdata_o.lower = item_i.range_low;
  assign range_wdata_o.base  = item_i.first_glyph;
  assign width_waddr_o       = GLYPH_AW'(item_i.slot);
  assign width_wdata_o       = item_i.pixel_width;
  assign width_raddr_o       = GLYPH_AW'(glyph_full);

  assign res_o.glyph_number = glyph_q;
  assign res_o.found        = hit_q;
  assign res_o.total_width  = sum_sat;
  assign res_o.string_done  = last_q;

  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    first_d       = first_q;
    count_d       = count_q;
    cp_d          = cp_q;
    last_d        = last_q;
    hit_d         = hit_q;
    glyph_d       = glyph_q;
    total_d       = total_q;
    range_we_o    = 1'b0;
    width_we_o    = 1'b0;
    range_re_o    = 1'b0;
    range_raddr_o = '0;
    width_re_o    = 1'b0;
    res_valid_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (item_i.opcode)
            glru_pkg::OP_LOAD_RANGE: begin
              range_we_o = (32'(item_i.slot) < RANGE_ENTRIES);
            end
            glru_pkg::OP_LOAD_WIDTH: begin
              width_we_o = (32'(item_i.slot) < GLYPH_ENTRIES);
            end
            glru_pkg::OP_MEASURE: begin
              n_d           = n_lim;
              first_d       = '0;
              count_d       = n_lim;
              cp_d          = item_i.code_point;
              last_d        = item_i.last_char;
              range_re_o    = 1'b1;
              range_raddr_o = RANGE_AW'(n_lim >> 1);
              state_d       = (n_lim != '0) ? ST_SEARCH : ST_CHECK;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        first_d    = first_nx;
        count_d    = count_nx;
        range_re_o = 1'b1;
        if (count_nx != '0) begin
          range_raddr_o = RANGE_AW'(first_nx + (count_nx >> 1));
        end else begin
          range_raddr_o = RANGE_AW'(first_nx);
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        width_re_o = 1'b1;
        hit_d      = hit_now;
        glyph_d    = hit_now ? glyph_full[glru_pkg::GLYPH_W-1:0] : '0;
        state_d    = ST_ACCUM;
      end
      ST_ACCUM: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          total_d = last_q ? '0 : sum_sat;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    first_q <= first_d;
    count_q <= count_d;
    cp_q    <= cp_d;
    last_q  <= last_d;
    hit_q   <= hit_d;
    glyph_q <= glyph_d;
  end

  `GLRU_ASSERT_IMP(a_search_has_work, state_q == ST_SEARCH, count_q != '0,
                   "search step with an empty interval")
  `GLRU_ASSERT_IMP(a_final_within_count, state_q == ST_CHECK, first_q <= n_q,
                   "search position beyond the ranges in use")
  `GLRU_ASSERT_IMP(a_table_write_idle, range_we_o || width_we_o, state_q == ST_IDLE,
                   "table written during a lookup")
  `GLRU_ASSERT_NXT(a_check_then_accum, state_q == ST_CHECK, state_q == ST_ACCUM,
                   "width read not followed by accumulate")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the glyph range lookup width sum unit
module tb_top;

  localparam int unsigned RANGE_DEPTH     = 256;
  localparam int unsigned GLYPH_DEPTH     = 1024;
  localparam int unsigned CP_MAX          = 1114111;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned MAX_REPORTS     = 40;
  localparam int unsigned LONG_STRING_LEN = 20;

  localparam logic [glru_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  class width_sum_tracker;
    bit [glru_pkg::CP_W-1:0]    upper_tab [RANGE_DEPTH];
    bit [glru_pkg::CP_W-1:0]    lower_tab [RANGE_DEPTH];
    bit [glru_pkg::GLYPH_W-1:0] base_tab  [RANGE_DEPTH];
    bit [glru_pkg::PIXEL_W-1:0] width_tab [GLYPH_DEPTH];
    int unsigned                ranges_live;
    int unsigned                string_total;
    glru_pkg::result_t          awaited [$];
    int unsigned                mismatches;

    // glyph for a code point under the current tables, -1 when not found
    function int glyph_for(bit [glru_pkg::CP_W-1:0] cp);
      int unsigned n, start, count, half, probe, glyph;
      n = (ranges_live > RANGE_DEPTH) ? RANGE_DEPTH : ranges_live;
      start = 0;
      count = n;
      while (count > 0) begin
        half  = count / 2;
        probe = start + half;
        if (upper_tab[probe] < cp) begin
          start = probe + 1;
          count = count - half - 1;
        end else begin
          count = half;
        end
      end
      if (start >= n) return -1;
      if (cp < lower_tab[start] || cp > upper_tab[start]) return -1;
      glyph = base_tab[start] + (cp - lower_tab[start]);
      if (glyph >= GLYPH_DEPTH) return -1;
      return glyph;
    endfunction

    function void note_item(glru_pkg::item_t it);
      int                glyph;
      glru_pkg::result_t want;
      case (it.opcode)
        glru_pkg::OP_LOAD_RANGE: begin
          if (it.slot < RANGE_DEPTH) begin
            lower_tab[it.slot] = it.range_low;
            upper_tab[it.slot] = it.range_high;
            base_tab[it.slot]  = it.first_glyph;
          end
        end
        glru_pkg::OP_LOAD_WIDTH: begin
          if (it.slot < GLYPH_DEPTH) width_tab[it.slot] = it.pixel_width;
        end
        glru_pkg::OP_MEASURE: begin
          glyph = glyph_for(it.code_point);
          if (glyph >= 0) begin
            string_total = string_total + width_tab[glyph];
            if (string_total > glru_pkg::TOTAL_MAX) string_total = glru_pkg::TOTAL_MAX;
          end
          want.glyph_number = (glyph >= 0) ? glru_pkg::GLYPH_W'(glyph) : '0;
          want.found        = (glyph >= 0);
          want.total_width  = glru_pkg::TOTAL_W'(string_total);
          want.string_done  = it.last_char;
          awaited.push_back(want);
          if (it.last_char) string_total = 0;
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: %s expected %0d got %0d", $time, label, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(glru_pkg::result_t got);
      glru_pkg::result_t want;
      if (awaited.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected item expected none got glyph %0d found %0d total %0d",
                   $time, got.glyph_number, got.found, got.total_width);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("glyph_number", want.glyph_number, got.glyph_number);
      compare_field("found", want.found, got.found);
      compare_field("total_width", want.total_width, got.total_width);
      compare_field("string_done", want.string_done, got.string_done);
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [glru_pkg::APB_ADDR_W-1:0] paddr;
  logic [glru_pkg::APB_DATA_W-1:0] pwdata;
  logic [glru_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // slot, code_point, range_low, range_high, first_glyph, pixel_width, zero fill
  logic [95:0]                     s_axis_tdata;
  // opcode
  logic [1:0]                      s_axis_tuser;
  logic                            s_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // glyph_number, total_width, zero fill
  logic [39:0]                     m_axis_tdata;
  // found
  logic [0:0]                      m_axis_tuser;
  logic                            m_axis_tlast;

  width_sum_tracker  tracker = new();
  glru_pkg::result_t observed;
  bit                width_loaded [GLYPH_DEPTH];
  int unsigned       send_gap_pct   = 16;
  int unsigned       recv_stall_pct = 48;
  int unsigned       hold_requests  = 0;
  int unsigned       holds_served   = 0;
  int unsigned       hold_left      = 0;
  int unsigned       cycle_count    = 0;

  glyph_range_lookup_width_sum_unit #(
    .RANGE_ENTRIES(RANGE_DEPTH),
    .GLYPH_ENTRIES(GLYPH_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served  <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      observed.glyph_number = m_axis_tdata[9:0];
      observed.total_width  = m_axis_tdata[33:10];
      observed.found        = m_axis_tuser[0];
      observed.string_done  = m_axis_tlast;
      tracker.check_result(observed);
    end
  end

  function automatic glru_pkg::item_t filled_item(logic [glru_pkg::OPCODE_W-1:0] op);
    glru_pkg::item_t it;
    it.opcode      = op;
    it.slot        = glru_pkg::SLOT_W'($urandom_range(1023));
    it.code_point  = glru_pkg::CP_W'($urandom_range(CP_MAX));
    it.range_low   = glru_pkg::CP_W'($urandom_range(CP_MAX));
    it.range_high  = glru_pkg::CP_W'($urandom_range(CP_MAX));
    it.first_glyph = glru_pkg::GLYPH_W'($urandom_range(1023));
    it.pixel_width = glru_pkg::PIXEL_W'($urandom_range(255));
    it.last_char   = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic send_item(input glru_pkg::item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, it.pixel_width, it.first_glyph, it.range_high, it.range_low,
                      it.code_point, it.slot};
    s_axis_tuser  <= it.opcode;
    s_axis_tlast  <= it.last_char;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_item(it);
  endtask

  task automatic load_range(input int unsigned slot, input int unsigned lo,
                            input int unsigned hi, input int unsigned base);
    glru_pkg::item_t it;
    it             = filled_item(glru_pkg::OP_LOAD_RANGE);
    it.slot        = glru_pkg::SLOT_W'(slot);
    it.range_low   = glru_pkg::CP_W'(lo);
    it.range_high  = glru_pkg::CP_W'(hi);
    it.first_glyph = glru_pkg::GLYPH_W'(base);
    send_item(it);
  endtask

  task automatic load_width(input int unsigned slot, input int unsigned pw);
    glru_pkg::item_t it;
    it             = filled_item(glru_pkg::OP_LOAD_WIDTH);
    it.slot        = glru_pkg::SLOT_W'(slot);
    it.pixel_width = glru_pkg::PIXEL_W'(pw);
    width_loaded[slot] = 1'b1;
    send_item(it);
  endtask

  // a hit needs a defined width, so a missing one is loaded first
  task automatic measure(input int unsigned cp, input bit last);
    int              glyph;
    glru_pkg::item_t it;
    glyph = tracker.glyph_for(glru_pkg::CP_W'(cp));
    if (glyph >= 0 && !width_loaded[glyph]) load_width(glyph, $urandom_range(255));
    it            = filled_item(glru_pkg::OP_MEASURE);
    it.code_point = glru_pkg::CP_W'(cp);
    it.last_char  = last;
    send_item(it);
  endtask

  task automatic send_noise();
    glru_pkg::item_t it;
    if ($urandom_range(1) == 0) begin
      it = filled_item(OP_UNUSED);
    end else begin
      it      = filled_item(glru_pkg::OP_LOAD_RANGE);
      it.slot = glru_pkg::SLOT_W'($urandom_range(1023, RANGE_DEPTH));
    end
    send_item(it);
  endtask

  task automatic random_measures(input int count);
    int unsigned live, idx;
    repeat (count) begin
      if ($urandom_range(9) == 0) send_noise();
      live = (tracker.ranges_live > RANGE_DEPTH) ? RANGE_DEPTH : tracker.ranges_live;
      if (live > 0 && $urandom_range(99) < 75) begin
        idx = $urandom_range(live - 1);
        measure($urandom_range(tracker.upper_tab[idx], tracker.lower_tab[idx]),
                $urandom_range(7) == 0);
      end else begin
        measure($urandom_range(CP_MAX), $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic await_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle_and_configure(input int unsigned value);
    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {glru_pkg::REG_RANGES_IN_USE, 2'b00};
    pwdata  <= ($urandom() & ~32'h1FF) | (value & 32'h1FF);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.ranges_live = value & 32'h1FF;
  endtask

  task automatic load_full_table();
    int unsigned cursor, lo, hi;
    cursor = 0;
    for (int unsigned i = 0; i < RANGE_DEPTH; i++) begin
      lo = (i == 0) ? 0 : cursor + $urandom_range(3000);
      hi = (i == RANGE_DEPTH - 1) ? CP_MAX : lo + $urandom_range(12);
      load_range(i, lo, hi, $urandom_range(1023));
      cursor = hi + 1;
    end
  endtask

  task automatic load_small_table(input int unsigned k, input bit sorted);
    int unsigned cursor, lo, hi;
    cursor = $urandom_range(CP_MAX - 20000);
    for (int unsigned i = 0; i < k; i++) begin
      if (sorted) begin
        lo     = cursor + $urandom_range(50);
        hi     = lo + $urandom_range(20);
        cursor = hi + 1;
      end else begin
        lo = cursor + $urandom_range(400);
        hi = cursor + $urandom_range(400);
      end
      load_range(i, lo, hi, $urandom_range(1023));
    end
  endtask

  initial begin
    int unsigned k;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= glru_pkg::OP_LOAD_RANGE;
    s_axis_tlast  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty range table: everything misses; then out-of-range loads and a table of three ranges
    measure(0, 1'b0);
    measure(CP_MAX, 1'b1);
    send_item(filled_item(OP_UNUSED));
    load_range(1023, 5, 9, 3);
    load_range(RANGE_DEPTH, 5, 9, 3);
    load_width(0, 255);
    load_width(1023, 0);
    load_width(1, 128);
    load_range(0, 'h41, 'h5A, 0);
    load_range(1, 'h100, 'h1FF, 900);
    load_range(2, 'h10FF00, CP_MAX, 1023);
    settle_and_configure(3);
    measure('h41, 1'b0);
    measure('h40, 1'b0);
    measure('h5A, 1'b0);
    measure('h150, 1'b0);
    measure('h1FF, 1'b0);
    measure('h10FF00, 1'b0);
    measure(CP_MAX, 1'b0);
    measure('h200, 1'b1);

    // full sorted table with a long receiver hold-off, then a count beyond the table depth and zero
    load_full_table();
    settle_and_configure(RANGE_DEPTH);
    random_measures(50);
    hold_requests = hold_requests + 1;
    random_measures(15);
    settle_and_configure(511);
    random_measures(30);
    settle_and_configure(0);
    random_measures(5);

    send_gap_pct   = 48;
    recv_stall_pct = 16;
    repeat (4) begin
      k = $urandom_range(16, 1);
      load_small_table(k, $urandom_range(3) != 0);
      repeat (3) load_width($urandom_range(1023), $urandom_range(255));
      settle_and_configure(($urandom_range(3) == 0) ? $urandom_range(511) : k);
      random_measures(12);
      await_results();
      random_measures(12);
    end

    // one long string of the widest glyph
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    load_range(0, 'h20, 'h20, 5);
    load_width(5, 255);
    settle_and_configure(1);
    repeat (LONG_STRING_LEN) measure('h20, 1'b0);
    measure('h20, 1'b1);
    measure('h20, 1'b1);
    measure('h21, 1'b1);

    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ glyph_range_lookup_width_sum_unit.f @@
+incdir+src
src/glru_pkg.sv
src/glru_range_store.sv
src/glru_width_store.sv
src/glru_ctrl.sv
src/glyph_range_lookup_width_sum_unit.sv
sim/tb_top.sv
